// ===== rtl/ddpu_pkg.sv =====
// Shared types and constants for the differential-drive pose update block.
// No dependencies; used by the CORDIC unit and the top level.
`default_nettype none

package ddpu_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_MAG_W   = 25;
    localparam int LEN_W        = 36;
    localparam int DIV_D_W      = 17;

    localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;
    // round(2^32 / (2*pi))
    localparam logic [29:0] TURN_PER_RAD    = 30'd683565276;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335086,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
        32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
        32'd20,        32'd10,        32'd5,         32'd2,        32'd1
    };

    // Sine or cosine in sign-magnitude form, magnitude Q.24
    typedef struct packed {
        logic                  neg;
        logic [TRIG_MAG_W-1:0] mag;
    } trig_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG_OLD,
        ST_CASTER_X,
        ST_CASTER_Y,
        ST_TURN_DIV,
        ST_RADIUS_DIV,
        ST_PIVOT_X,
        ST_PIVOT_Y,
        ST_TRIG_NEW,
        ST_MOVE_X,
        ST_MOVE_Y,
        ST_DONE
    } ddpu_state_t;

    typedef enum logic [1:0] {
        KIND_STRAIGHT = 2'd0,
        KIND_SPIN     = 2'd1,
        KIND_ARC      = 2'd2
    } motion_kind_t;

endpackage

`default_nettype wire

// ===== rtl/diff_drive_pose_update_core.sv =====
// Differential-drive odometry core: top level with sequencer and digit-serial multiplier.
// Depends on ddpu_pkg, ddpu_cordic and ddpu_div.
//
// Each request carries the signed Q8.8 travel of the left and right wheels for one tick and
// advances the stored pose (x, y in Q.8, binary-angle heading). The result carries the new
// pose, the caster point of the pose before the step, the pivot and the motion kind
// (straight, spin in place, arc). One request is worked at a time; a finished result sits
// in an output register, so the next request is taken while it waits. The work is done
// by the 30-step CORDIC (once, or twice for an arc), the 36-step restoring divider (heading
// change, plus the arc radius) and the radix-16 multiplier that forms each length-times-trig
// product in 9 digit steps (two products for a spin, four for straight motion, six for an
// arc). Configuration (wheel base, caster offset) is written through its own channel; the
// user must write it only while the core is idle, which the core itself does not enforce.
// A wheel base of zero acts as one. Positions wrap on overflow.
`default_nettype none

module diff_drive_pose_update_core
    import ddpu_pkg::*;
#(
    parameter int POS_BITS   = 32,
    parameter int ANGLE_BITS = 16
)(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [9:0]                 cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         left_travel,
    input  logic signed [15:0]         right_travel,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [POS_BITS-1:0] pose_x,
    output logic signed [POS_BITS-1:0] pose_y,
    output logic [ANGLE_BITS-1:0]      pose_heading,
    output logic signed [POS_BITS-1:0] caster_x,
    output logic signed [POS_BITS-1:0] caster_y,
    output logic signed [POS_BITS-1:0] pivot_x,
    output logic signed [POS_BITS-1:0] pivot_y,
    output logic [1:0]                 motion_kind
);

    // Register map
    localparam logic CFG_WHEEL_BASE    = 1'b0;
    localparam logic CFG_CASTER_OFFSET = 1'b1;

    // Multiplier geometry: a 36-bit length times a 25-bit trig magnitude, 4 bits per step
    localparam int PROD_W     = LEN_W + TRIG_MAG_W;
    localparam int MUL_HI_W   = TRIG_MAG_W + 4;
    localparam int MUL_W      = LEN_W + MUL_HI_W;
    localparam int MUL_DIGITS = LEN_W / 4;
    localparam int MCNT_W     = $clog2(MUL_DIGITS + 1);
    localparam int RND_W      = PROD_W + 1 - 24;
    localparam int EXT_W      = (POS_BITS > RND_W) ? POS_BITS : RND_W;
    localparam logic [MCNT_W-1:0] MUL_END = MCNT_W'(MUL_DIGITS);

    // Heading change divides by W * 2^TURN_SH; the power of two comes off before the divider
    localparam int TURN_SH    = 40 - ANGLE_BITS;
    localparam int TURN_SUM_W = 48;

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    ddpu_state_t         state_reg, state_next;
    logic                launch_reg;
    logic                out_valid_reg, out_valid_next;
    logic [MCNT_W-1:0]   mul_cnt_reg;
    logic [9:0]          wheel_base_reg, caster_offset_reg;
    logic [POS_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [ANGLE_BITS-1:0] heading_reg;

    // Working registers for the request in flight
    logic signed [15:0]    l_reg, r_reg;
    logic [46:0]           turn_prod_reg;
    logic [26:0]           radius_prod_reg;
    logic [MUL_W-1:0]      mul_p_reg;
    logic [TRIG_MAG_W-1:0] mul_t_reg;
    logic                  mul_neg_reg;
    logic                  d_neg_reg;
    logic [LEN_W-1:0]      d_mag_reg;
    logic [POS_BITS-1:0]   cx_reg, cy_reg, px_reg, py_reg, nx_reg, ny_reg;
    logic [ANGLE_BITS-1:0] nh_reg;

    // Output register
    logic [POS_BITS-1:0]   pose_x_reg, pose_y_reg, caster_x_reg, caster_y_reg;
    logic [POS_BITS-1:0]   pivot_x_reg, pivot_y_reg;
    logic [ANGLE_BITS-1:0] pose_heading_reg;
    motion_kind_t          motion_kind_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                  accept, commit;
    logic                  is_mul_state, mul_done;
    logic [9:0]            w_eff;
    logic signed [16:0]    diff_w, sum_w;
    logic [16:0]           diff_mag, sum_mag, l_mag;
    logic                  straight, spin;
    motion_kind_t          kind;

    logic                  cordic_start, cordic_done;
    logic [ANGLE_BITS-1:0] cordic_angle;
    trig_t                 cos_val, sin_val;

    logic                  div_start, div_done;
    logic [LEN_W-1:0]      div_dividend, div_quotient;
    logic [DIV_D_W-1:0]    div_divisor;
    logic [TURN_SUM_W-1:0] turn_sum;
    logic [ANGLE_BITS-1:0] turn_q;

    logic                  mul_a_neg;
    logic [LEN_W-1:0]      mul_a_mag;
    trig_t                 mul_t;
    logic [MUL_HI_W-1:0]   mul_hi_sum;
    logic [PROD_W:0]       mul_round;
    logic [EXT_W-1:0]      mul_ext;
    logic [POS_BITS-1:0]   mul_mag, mul_val;

    assign w_eff    = (wheel_base_reg == 10'd0) ? 10'd1 : wheel_base_reg;
    assign diff_w   = 17'(r_reg) - 17'(l_reg);
    assign sum_w    = 17'(l_reg) + 17'(r_reg);
    assign diff_mag = diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
    assign sum_mag  = sum_w[16] ? 17'(-sum_w) : 17'(sum_w);
    assign l_mag    = l_reg[15] ? 17'(-17'(l_reg)) : 17'(l_reg);
    assign straight = (l_reg == r_reg);
    assign spin     = (sum_w == 17'sd0);

    always_comb
    begin
        priority if (straight)
            kind = KIND_STRAIGHT;
        else if (spin)
            kind = KIND_SPIN;
        else
            kind = KIND_ARC;
    end

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        commit         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_TRIG_OLD;
            ST_TRIG_OLD:
                if (cordic_done)
                    state_next = ST_CASTER_X;
            ST_CASTER_X:
                if (mul_done)
                    state_next = ST_CASTER_Y;
            ST_CASTER_Y:
                if (mul_done)
                    state_next = straight ? ST_MOVE_X : ST_TURN_DIV;
            ST_TURN_DIV:
                if (div_done)
                    state_next = spin ? ST_DONE : ST_RADIUS_DIV;
            ST_RADIUS_DIV:
                if (div_done)
                    state_next = ST_PIVOT_X;
            ST_PIVOT_X:
                if (mul_done)
                    state_next = ST_PIVOT_Y;
            ST_PIVOT_Y:
                if (mul_done)
                    state_next = ST_TRIG_NEW;
            ST_TRIG_NEW:
                if (cordic_done)
                    state_next = ST_MOVE_X;
            ST_MOVE_X:
                if (mul_done)
                    state_next = ST_MOVE_Y;
            ST_MOVE_Y:
                if (mul_done)
                    state_next = ST_DONE;
            ST_DONE:
                // hold the finished result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            launch_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            mul_cnt_reg       <= MUL_END;
            wheel_base_reg    <= 10'd64;
            caster_offset_reg <= 10'd32;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            heading_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            // a state change raises launch, which starts the unit of the new state, if it has one
            launch_reg    <= (state_next != state_reg);
            out_valid_reg <= out_valid_next;

            if (launch_reg && is_mul_state)
                mul_cnt_reg <= '0;
            else if (mul_cnt_reg != MUL_END)
                mul_cnt_reg <= mul_cnt_reg + 1'b1;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WHEEL_BASE:    wheel_base_reg    <= cfg_data;
                    CFG_CASTER_OFFSET: caster_offset_reg <= cfg_data;
                    default:           wheel_base_reg    <= wheel_base_reg;
                endcase
            end

            if (commit)
            begin
                pos_x_reg   <= nx_reg;
                pos_y_reg   <= ny_reg;
                heading_reg <= nh_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: old heading first, then the new heading for an arc
    // ------------------------------------------------------------------
    assign cordic_start = launch_reg &&
                          (state_reg == ST_TRIG_OLD || state_reg == ST_TRIG_NEW);
    assign cordic_angle = (state_reg == ST_TRIG_NEW) ? nh_reg : heading_reg;

    ddpu_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // ------------------------------------------------------------------
    // Divider: heading change, then arc radius
    // ------------------------------------------------------------------
    // floor((n + W*2^(S-1)) / (W*2^S)) == floor(floor((n + W*2^(S-1)) / 2^S) / W)
    assign turn_sum  = TURN_SUM_W'(turn_prod_reg) + (TURN_SUM_W'(w_eff) << (TURN_SH - 1));
    assign div_start = launch_reg &&
                       (state_reg == ST_TURN_DIV || state_reg == ST_RADIUS_DIV);

    always_comb
    begin
        if (state_reg == ST_RADIUS_DIV)
        begin
            div_dividend = LEN_W'({radius_prod_reg, 7'b0}) + LEN_W'(diff_mag >> 1);
            div_divisor  = diff_mag;
        end
        else
        begin
            div_dividend = LEN_W'(turn_sum >> TURN_SH);
            div_divisor  = DIV_D_W'(w_eff);
        end
    end

    ddpu_div #(
        .N_W (LEN_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign turn_q = div_quotient[ANGLE_BITS-1:0];

    // ------------------------------------------------------------------
    // Radix-16 multiplier: length times trig, rounded to Q.8
    // ------------------------------------------------------------------
    always_comb
    begin
        is_mul_state = 1'b1;
        mul_a_neg    = 1'b0;
        mul_a_mag    = LEN_W'({caster_offset_reg, 8'b0});
        mul_t        = sin_val;
        unique case (state_reg)
            ST_CASTER_X:
                mul_t = sin_val;
            ST_CASTER_Y:
                mul_t = cos_val;
            ST_PIVOT_X:
            begin
                mul_a_neg = d_neg_reg;
                mul_a_mag = d_mag_reg;
                mul_t     = cos_val;
            end
            ST_PIVOT_Y:
            begin
                mul_a_neg = d_neg_reg;
                mul_a_mag = d_mag_reg;
                mul_t     = sin_val;
            end
            ST_MOVE_X:
            begin
                mul_a_neg = straight ? l_reg[15] : d_neg_reg;
                mul_a_mag = straight ? LEN_W'(l_mag) : d_mag_reg;
                mul_t     = straight ? sin_val : cos_val;
            end
            ST_MOVE_Y:
            begin
                mul_a_neg = straight ? l_reg[15] : d_neg_reg;
                mul_a_mag = straight ? LEN_W'(l_mag) : d_mag_reg;
                mul_t     = straight ? cos_val : sin_val;
            end
            default:
                is_mul_state = 1'b0;
        endcase
    end

    assign mul_hi_sum = mul_p_reg[MUL_W-1:LEN_W] +
                        MUL_HI_W'(mul_t_reg) * MUL_HI_W'(mul_p_reg[3:0]);
    assign mul_done   = is_mul_state && !launch_reg && (mul_cnt_reg == MUL_END);
    assign mul_round  = (PROD_W + 1)'(mul_p_reg[PROD_W-1:0]) + (PROD_W + 1)'(1 << 23);
    assign mul_ext    = EXT_W'(mul_round[PROD_W:24]);
    assign mul_mag    = mul_ext[POS_BITS-1:0];
    assign mul_val    = mul_neg_reg ? -mul_mag : mul_mag;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // products are needed only after the first CORDIC pass
        turn_prod_reg   <= 47'(diff_mag) * 47'(TURN_PER_RAD);
        radius_prod_reg <= 27'(sum_mag) * 27'(w_eff);

        if (launch_reg && is_mul_state)
        begin
            mul_p_reg   <= {MUL_HI_W'(0), mul_a_mag};
            mul_t_reg   <= mul_t.mag;
            mul_neg_reg <= mul_a_neg ^ mul_t.neg;
        end
        else if (mul_cnt_reg != MUL_END)
            mul_p_reg <= {4'b0000, mul_hi_sum, mul_p_reg[LEN_W-1:4]};

        if (accept)
        begin
            l_reg  <= left_travel;
            r_reg  <= right_travel;
            nx_reg <= pos_x_reg;
            ny_reg <= pos_y_reg;
            px_reg <= '0;
            py_reg <= '0;
            nh_reg <= heading_reg;
        end

        if (div_done && state_reg == ST_TURN_DIV)
        begin
            // right ahead of left turns the heading down
            nh_reg <= diff_w[16] ? heading_reg + turn_q : heading_reg - turn_q;
            if (spin)
            begin
                px_reg <= pos_x_reg;
                py_reg <= pos_y_reg;
            end
        end

        if (div_done && state_reg == ST_RADIUS_DIV)
        begin
            d_mag_reg <= div_quotient;
            d_neg_reg <= sum_w[16] ^ diff_w[16];
        end

        if (mul_done)
        begin
            unique case (state_reg)
                ST_CASTER_X: cx_reg <= pos_x_reg + mul_val;
                ST_CASTER_Y: cy_reg <= pos_y_reg - mul_val;
                ST_PIVOT_X:  px_reg <= pos_x_reg - mul_val;
                ST_PIVOT_Y:  py_reg <= pos_y_reg - mul_val;
                ST_MOVE_X:   nx_reg <= (straight ? pos_x_reg : px_reg) + mul_val;
                ST_MOVE_Y:   ny_reg <= straight ? pos_y_reg - mul_val : py_reg + mul_val;
                default:     cx_reg <= cx_reg;
            endcase
        end

        if (commit)
        begin
            pose_x_reg       <= nx_reg;
            pose_y_reg       <= ny_reg;
            pose_heading_reg <= nh_reg;
            caster_x_reg     <= cx_reg;
            caster_y_reg     <= cy_reg;
            pivot_x_reg      <= px_reg;
            pivot_y_reg      <= py_reg;
            motion_kind_reg  <= kind;
        end
    end

    assign pose_x       = $signed(pose_x_reg);
    assign pose_y       = $signed(pose_y_reg);
    assign pose_heading = pose_heading_reg;
    assign caster_x     = $signed(caster_x_reg);
    assign caster_y     = $signed(caster_y_reg);
    assign pivot_x      = $signed(pivot_x_reg);
    assign pivot_y      = $signed(pivot_y_reg);
    assign motion_kind  = motion_kind_reg;

endmodule

`default_nettype wire

// ===== rtl/ddpu_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, 30 steps.
// Depends on ddpu_pkg (arctangent table, gain constant, trig_t).
`default_nettype none

module ddpu_cordic
    import ddpu_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  done,
    output trig_t                 cos_val,
    output trig_t                 sin_val
);

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [4:0]         step_reg, step_next;
    logic               flip_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;

    logic [31:0]        phase;
    logic               flip;
    logic signed [33:0] z_init;
    logic [33:0]        ax, ay, axs, ays;
    logic signed [33:0] xs, ys, atan_ext;
    logic [33:0]        x_rnd, y_rnd;

    assign phase  = {angle, (32 - ANGLE_BITS)'(0)};
    assign flip   = phase[31] ^ phase[30];
    assign z_init = {{3{phase[31] ^ flip}}, phase[30:0]};

    // Shifts truncate toward zero: shift the magnitude, restore the sign
    always_comb
    begin
        ax       = x_reg[33] ? 34'(-x_reg) : 34'(x_reg);
        ay       = y_reg[33] ? 34'(-y_reg) : 34'(y_reg);
        axs      = ax >> step_reg;
        ays      = ay >> step_reg;
        xs       = x_reg[33] ? -$signed(axs) : $signed(axs);
        ys       = y_reg[33] ? -$signed(ays) : $signed(ays);
        atan_ext = $signed({2'b00, ATAN_TURNS[step_reg]});
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 5'd1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed({2'b00, CORDIC_INV_GAIN});
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip;
        end
        else if (run_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_ext;
            end
        end
    end

    // Round half away from zero down to Q.24
    assign x_rnd = ax + 34'd32;
    assign y_rnd = ay + 34'd32;

    assign cos_val.neg = x_reg[33] ^ flip_reg;
    assign cos_val.mag = x_rnd[30:6];
    assign sin_val.neg = y_reg[33] ^ flip_reg;
    assign sin_val.mag = y_rnd[30:6];
    assign done        = done_reg;

endmodule

`default_nettype wire

// ===== rtl/ddpu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package dependency.
`default_nettype none

module ddpu_div
#(
    parameter int N_W = 36,
    parameter int D_W = 17
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N_W - 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, dsr_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W:0]     trial, trial_sub;

    assign trial     = {rem_reg, quo_reg[N_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!trial_sub[D_W])
            begin
                rem_reg <= trial_sub[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== bench/diff_drive_pose_update_core_test.sv =====
// Self-checking bench for diff_drive_pose_update_core: directed and random wheel-travel
// requests, a bit-exact odometry predictor and an in-order result checker.
// Depends on ddpu_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_pose_update_core_test;
    import ddpu_pkg::*;

    localparam logic REG_WHEEL_BASE    = 1'b0;
    localparam logic REG_CASTER_OFFSET = 1'b1;
    localparam int   LIMIT_CYCLES      = 6_000_000;
    localparam int   DRAIN_CYCLES      = 300;
    localparam longint TURN_K          = 683565276;
    localparam longint INV_GAIN        = 652032874;

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
    } travel_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [1:0]         kind;
    } pose_rec_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [9:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] left_travel;
    logic signed [15:0] right_travel;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] pose_x, pose_y, caster_x, caster_y, pivot_x, pivot_y;
    logic [15:0] pose_heading;
    logic [1:0]  motion_kind;

    diff_drive_pose_update_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .left_travel(left_travel), .right_travel(right_travel),
        .out_valid(out_valid), .out_ready(out_ready),
        .pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
        .caster_x(caster_x), .caster_y(caster_y),
        .pivot_x(pivot_x), .pivot_y(pivot_y), .motion_kind(motion_kind)
    );

    // Predictor state: pose plus a mirror of the configuration registers
    logic signed [31:0] odo_x, odo_y;
    logic [15:0]        odo_heading;
    logic [9:0]         odo_wheel_base;
    logic [9:0]         odo_caster;

    travel_t   travel_q[$];
    pose_rec_t pose_expect_q[$];
    int n_queued;
    int n_results;
    int n_errors;
    int cycles;
    int gap_left;
    int stall_left;
    bit in_fire;
    bit idle_on;
    bit hold_off;
    bit random_started;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- fixed-point helpers ----------------
    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint signed_of(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint div_nearest(longint n, longint d);
        longint unsigned dm;
        dm = mag64(d);
        return signed_of((mag64(n) + dm / 2) / dm, (n < 0) != (d < 0));
    endfunction

    // Length times Q.24 trig value, rounded half away from zero to Q.8
    function automatic longint scale_trig(longint a, longint t);
        longint unsigned m;
        m = mag64(a) * mag64(t);
        return signed_of((m + 64'd8388608) >> 24, (a < 0) != (t < 0));
    endfunction

    // 30-step CORDIC, shifts truncate toward zero, result rounded to Q.24
    task automatic sin_cos(input logic [15:0] angle, output longint cv, output longint sv);
        logic [31:0] p;
        bit flip;
        longint x, y, z, xs, ys;
        p = {angle, 16'h0000};
        flip = 1'b0;
        x = INV_GAIN;
        y = 0;
        if (p >= 32'h4000_0000 && p < 32'hC000_0000)
        begin
            flip = 1'b1;
            p = p - 32'h8000_0000;
        end
        z = longint'(signed'(p));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = signed_of(mag64(x) >> i, x < 0);
            ys = signed_of(mag64(y) >> i, y < 0);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cv = signed_of((mag64(x) + 32) >> 6, x < 0);
        sv = signed_of((mag64(y) + 32) >> 6, y < 0);
    endtask

    // Advance the predicted pose by one tick and return the expected result
    task automatic odo_step(input travel_t t, output pose_rec_t res);
        longint l, r, w, cst, c, s, c2, s2, d, delta;
        logic signed [31:0] nx, ny, vx, vy;
        logic [15:0] nh;
        logic [1:0]  kind;
        l = t.l;
        r = t.r;
        w = (odo_wheel_base == 0) ? 1 : odo_wheel_base;
        cst = longint'(odo_caster) * 256;
        nx = odo_x;
        ny = odo_y;
        nh = odo_heading;
        vx = '0;
        vy = '0;
        sin_cos(odo_heading, c, s);
        res.cx = 32'(longint'(odo_x) + scale_trig(cst, s));
        res.cy = 32'(longint'(odo_y) - scale_trig(cst, c));
        if (l == r)
        begin
            kind = KIND_STRAIGHT;
            nx = 32'(longint'(odo_x) + scale_trig(l, s));
            ny = 32'(longint'(odo_y) - scale_trig(l, c));
        end
        else
        begin
            delta = div_nearest((l - r) * TURN_K, w << 24);
            nh = 16'(longint'(odo_heading) + delta);
            if (l + r == 0)
            begin
                kind = KIND_SPIN;
                vx = odo_x;
                vy = odo_y;
            end
            else
            begin
                kind = KIND_ARC;
                d = div_nearest(w * (l + r) * 128, r - l);
                vx = 32'(longint'(odo_x) - scale_trig(d, c));
                vy = 32'(longint'(odo_y) - scale_trig(d, s));
                sin_cos(nh, c2, s2);
                nx = 32'(longint'(vx) + scale_trig(d, c2));
                ny = 32'(longint'(vy) + scale_trig(d, s2));
            end
        end
        odo_x = nx;
        odo_y = ny;
        odo_heading = nh;
        res.px = nx;
        res.py = ny;
        res.hd = nh;
        res.vx = vx;
        res.vy = vy;
        res.kind = kind;
    endtask

    function automatic int pick_gap(int long_max);
        if (!idle_on)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, long_max);
        return $urandom_range(0, 2);
    endfunction

    // ---------------- request driver: change inputs on the falling edge ----------------
    always @(negedge clk)
    begin : req_drive
        logic nv;
        travel_t t;
        if (rst_n)
        begin
            nv = in_valid;
            // drop valid once the request went through at the last rising edge
            if (in_fire)
                nv = 1'b0;
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (travel_q.size() > 0)
                begin
                    t = travel_q.pop_front();
                    left_travel <= t.l;
                    right_travel <= t.r;
                    nv = 1'b1;
                    gap_left = pick_gap(120);
                end
            end
            in_valid <= nv;
        end
    end

    // ---------------- result side: random stalls plus the long hold-off ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(300);
            end
        end
    end

    // Hold the result channel closed for a long stretch while requests keep coming,
    // so the core backs up and stalls its input.
    initial
    begin
        hold_off = 1'b0;
        wait (random_started);
        repeat (40) @(negedge clk);
        hold_off = 1'b1;
        repeat (800) @(negedge clk);
        hold_off = 1'b0;
    end

    // ---------------- monitor: sample on the rising edge ----------------
    always @(posedge clk)
    begin : mon
        pose_rec_t exp_r, got;
        travel_t t;
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            t.l = left_travel;
            t.r = right_travel;
            odo_step(t, exp_r);
            pose_expect_q.insert(pose_expect_q.size(), exp_r);
        end
        if (out_valid && out_ready)
        begin
            n_results++;
            got = '{pose_x, pose_y, pose_heading, caster_x, caster_y, pivot_x, pivot_y,
                    motion_kind};
            if (pose_expect_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                exp_r = pose_expect_q.pop_front();
                if (got.px !== exp_r.px || got.py !== exp_r.py || got.hd !== exp_r.hd ||
                    got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.vx !== exp_r.vx ||
                    got.vy !== exp_r.vy || got.kind !== exp_r.kind)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d mismatch\n  exp %p\n  got %p",
                                 n_results, exp_r, got);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    task automatic add_travel(input int l, input int r);
        travel_t t;
        t.l = 16'(l);
        t.r = 16'(r);
        travel_q.insert(travel_q.size(), t);
        n_queued++;
    endtask

    // Wait until every request has produced its result
    task automatic drain();
        while (n_results < n_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES / 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WHEEL_BASE)
            odo_wheel_base = val;
        else
            odo_caster = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_batch(input int count);
        int sel;
        int a;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            a = $urandom_range(0, 65535) - 32768;
            case (sel)
                0:       add_travel(a, a);
                1:       add_travel(a, -a);
                2, 3:    add_travel($urandom_range(0, 65535) - 32768,
                                    $urandom_range(0, 65535) - 32768);
                default: add_travel($urandom_range(0, 1023) - 512,
                                    $urandom_range(0, 1023) - 512);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WHEEL_BASE;
        cfg_data = '0;
        in_valid = 1'b0;
        left_travel = '0;
        right_travel = '0;
        out_ready = 1'b0;
        n_queued = 0;
        n_results = 0;
        n_errors = 0;
        cycles = 0;
        gap_left = 0;
        stall_left = 0;
        in_fire = 1'b0;
        idle_on = 1'b1;
        random_started = 1'b0;
        odo_x = '0;
        odo_y = '0;
        odo_heading = '0;
        odo_wheel_base = 10'd64;
        odo_caster = 10'd32;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset configuration, straight, spin and arc at field extremes
        add_travel(0, 0);
        add_travel(256, 256);
        add_travel(32767, 32767);
        add_travel(-32768, -32768);
        add_travel(256, -256);
        add_travel(-32767, 32767);
        add_travel(32767, -32767);
        add_travel(256, 0);
        add_travel(0, 256);
        add_travel(-32768, 32767);
        add_travel(32767, -32768);
        add_travel(-1, 1);
        add_travel(1, 2);
        drain();

        // Zero wheel base acts as one; widest caster offset
        write_reg(REG_WHEEL_BASE, 10'd0);
        write_reg(REG_CASTER_OFFSET, 10'd1023);
        add_travel(100, -100);
        add_travel(300, 200);
        add_travel(-32768, 0);
        add_travel(5000, 5000);
        drain();

        write_reg(REG_WHEEL_BASE, 10'd1023);
        write_reg(REG_CASTER_OFFSET, 10'd0);
        add_travel(32767, -32768);
        add_travel(-32768, 32767);
        add_travel(32767, 32766);
        add_travel(1000, -1000);
        drain();

        // Random phases, with a settings change and a full drain between each
        random_started = 1'b1;
        random_batch(350);
        drain();

        write_reg(REG_WHEEL_BASE, 10'd1);
        write_reg(REG_CASTER_OFFSET, 10'd512);
        idle_on = 1'b0;     // back-to-back stretch: no gaps on either side
        random_batch(300);
        drain();
        idle_on = 1'b1;

        write_reg(REG_WHEEL_BASE, 10'($urandom_range(1, 1023)));
        write_reg(REG_CASTER_OFFSET, 10'($urandom_range(0, 1023)));
        random_batch(350);
        drain();

        write_reg(REG_WHEEL_BASE, 10'd64);
        write_reg(REG_CASTER_OFFSET, 10'd32);
        random_batch(300);
        drain();

        write_reg(REG_WHEEL_BASE, 10'($urandom_range(0, 1023)));
        write_reg(REG_CASTER_OFFSET, 10'($urandom_range(0, 1023)));
        random_batch(320);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && pose_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ddpu_pkg.sv
rtl/ddpu_cordic.sv
rtl/ddpu_div.sv
rtl/diff_drive_pose_update_core.sv
bench/diff_drive_pose_update_core_test.sv
